/* rtl/ffba_pkg.sv */
package ffba_pkg;

   localparam int ADDR_BITS    = 20;
   localparam int ALIGN_LOG    = 4;
   localparam int ALIGN_BYTES  = 1 << ALIGN_LOG;
   localparam int HEADER_BYTES = 16;
   localparam int MAX_BLOCKS   = 64;
   localparam int IDX_W        = $clog2(MAX_BLOCKS);
   localparam int CNT_W        = IDX_W + 1;
   localparam int OWNER_W      = 16;
   localparam int KIND_W       = 3;
   localparam int STATUS_W     = 3;
   localparam int AW1          = ADDR_BITS + 1;

   localparam logic [KIND_W-1:0] KIND_ADD        = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ALLOC      = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FREE_ADDR  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FREE_OWNER = 3'd3;
   localparam logic [KIND_W-1:0] KIND_LARGEST    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_SHRINK     = 3'd5;

   localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_SIZE      = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_NO_FIT    = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd4;

   typedef struct packed {
      logic [ADDR_BITS-1:0] addr;
      logic [ADDR_BITS-1:0] size;
      logic [OWNER_W-1:0]   owner;
      logic                 granted;
      logic                 pinned;
   } entry_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_EV,
      S_SHU_RD,
      S_SHU_WR,
      S_SHD_RD,
      S_SHD_WR,
      S_ADD_WR,
      S_ALLOC_NEW,
      S_ALLOC_CUR,
      S_REL0,
      S_REL1,
      S_REL2,
      S_REL3,
      S_REL_END,
      S_SHR_CHK,
      S_SHR_EV,
      S_SHR_NOM,
      S_SHR_NEW,
      S_SHR_CUR
   } state_type;

endpackage

/* rtl/first_fit_block_allocator.sv */
// First-fit block allocator over an address-ordered block table.
// Command channel: drive req_* with start high; the command is taken at
// the rising edge where start is high and busy is low. busy stays high
// while the command walks the table.
// Response channel: one beat per command. rsp_valid is high for exactly
// one cycle with rsp_status, rsp_result_address and rsp_largest_free;
// the receiver cannot stall, so it must take the beat in that cycle.
// Table: the block table sits in a RAM with one read port and one write
// port and a registered read. A table scan reads an entry and then checks
// it for each entry visited; opening or closing a slot reads and writes
// each entry moved, and free by owner adds a slot close per merge.
// Commands rejected on their request fields, and undefined commands, answer
// in the cycle after acceptance.
// A new command may be accepted in the cycle its predecessor's beat shows.
// Reset (synchronous, active high) empties the table by clearing the
// block count; table RAM contents are not cleared.
module first_fit_block_allocator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [ffba_pkg::KIND_W-1:0]           req_kind,
   input  logic [ffba_pkg::ADDR_BITS-1:0]        req_byte_address,
   input  logic [ffba_pkg::ADDR_BITS-1:0]        req_byte_count,
   input  logic [ffba_pkg::OWNER_W-1:0]          req_owner_id,
   output logic                                  rsp_valid,
   output logic [ffba_pkg::STATUS_W-1:0]         rsp_status,
   output logic [ffba_pkg::ADDR_BITS-1:0]        rsp_result_address,
   output logic [ffba_pkg::ADDR_BITS-1:0]        rsp_largest_free
);

   localparam int AB  = ffba_pkg::ADDR_BITS;
   localparam int AW1 = ffba_pkg::AW1;
   localparam int IW  = ffba_pkg::IDX_W;
   localparam int CW  = ffba_pkg::CNT_W;
   localparam logic [AB-1:0]  HDR    = AB'(ffba_pkg::HEADER_BYTES);
   localparam logic [AW1-1:0] HDR1   = AW1'(ffba_pkg::HEADER_BYTES);
   localparam logic [AW1-1:0] AMSK1  = AW1'(ffba_pkg::ALIGN_BYTES - 1);
   localparam logic [CW-1:0]  MAXB   = CW'(ffba_pkg::MAX_BLOCKS);
   localparam logic [AW1:0]   LIMIT  = (AW1 + 1)'(1) << AB;

   ffba_pkg::entry_type mem [ffba_pkg::MAX_BLOCKS];

   ffba_pkg::state_type state_ff, state_in, ret_ff, ret_in;
   logic [ffba_pkg::KIND_W-1:0]    kind_ff, kind_in;
   logic [AB-1:0]                  baddr_ff, baddr_in;
   logic [AB-1:0]                  need_ff, need_in;
   logic [AB-1:0]                  at_ff, at_in;
   logic [AB-1:0]                  tail_ff, tail_in;
   logic [ffba_pkg::OWNER_W-1:0]   owner_ff, owner_in;
   logic [CW-1:0]                  idx_ff, idx_in, kk_ff, kk_in, pos_ff, pos_in, cnt_ff, cnt_in;
   ffba_pkg::entry_type            cur_ff, cur_in, rd_q_ff;
   logic                           split_ff, split_in, any_ff, any_in, merged_ff, merged_in;
   logic [AB-1:0]                  largest_ff, largest_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [ffba_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [AB-1:0]                  rsp_raddr_ff, rsp_raddr_in;
   logic [AB-1:0]                  rsp_largest_ff, rsp_largest_in;

   logic                  rd_en, wr_en;
   logic [IW-1:0]         rd_addr, wr_addr;
   ffba_pkg::entry_type   wr_data;

   logic                           fin;
   logic [ffba_pkg::STATUS_W-1:0]  fin_status;
   logic [AB-1:0]                  fin_raddr, fin_largest;

   logic [ffba_pkg::ALIGN_LOG-1:0] add_rem;
   logic [AW1-1:0] add_step, add_start, add_size, add_trim, need_rnd;
   logic [AW1:0]   add_end;
   logic           add_bad;
   logic [CW-1:0]  idx_p1, idx_m1, kk_p1, kk_m1;
   logic [AB-1:0]  alloc_rest;

   assign add_rem   = req_byte_address[ffba_pkg::ALIGN_LOG-1:0];
   assign add_step  = AW1'(ffba_pkg::ALIGN_BYTES) - AW1'(add_rem);
   assign add_start = (add_rem != '0) ? ({1'b0, req_byte_address} + add_step)
                                      : {1'b0, req_byte_address};
   assign add_size  = (add_rem != '0) ? ({1'b0, req_byte_count} - add_step)
                                      : {1'b0, req_byte_count};
   assign add_trim  = add_size & ~AMSK1;
   assign add_end   = {1'b0, add_start} + {1'b0, add_trim};
   assign add_bad   = ((add_rem != '0) && ({1'b0, req_byte_count} < add_step))
                      || (add_trim < HDR1) || (add_end > LIMIT);
   assign need_rnd  = ({1'b0, req_byte_count} + AMSK1) & ~AMSK1;

   assign idx_p1     = idx_ff + CW'(1);
   assign idx_m1     = idx_ff - CW'(1);
   assign kk_p1      = kk_ff + CW'(1);
   assign kk_m1      = kk_ff - CW'(1);
   assign alloc_rest = rd_q_ff.size - need_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffba_pkg::S_IDLE;
         ret_ff       <= ffba_pkg::S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      baddr_ff       <= baddr_in;
      need_ff        <= need_in;
      at_ff          <= at_in;
      tail_ff        <= tail_in;
      owner_ff       <= owner_in;
      idx_ff         <= idx_in;
      kk_ff          <= kk_in;
      pos_ff         <= pos_in;
      cur_ff         <= cur_in;
      split_ff       <= split_in;
      any_ff         <= any_in;
      merged_ff      <= merged_in;
      largest_ff     <= largest_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_raddr_ff   <= rsp_raddr_in;
      rsp_largest_ff <= rsp_largest_in;
   end

   always_comb begin
      state_in       = state_ff;
      ret_in         = ret_ff;
      kind_in        = kind_ff;
      baddr_in       = baddr_ff;
      need_in        = need_ff;
      at_in          = at_ff;
      tail_in        = tail_ff;
      owner_in       = owner_ff;
      idx_in         = idx_ff;
      kk_in          = kk_ff;
      pos_in         = pos_ff;
      cnt_in         = cnt_ff;
      cur_in         = cur_ff;
      split_in       = split_ff;
      any_in         = any_ff;
      merged_in      = merged_ff;
      largest_in     = largest_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_raddr_in   = rsp_raddr_ff;
      rsp_largest_in = rsp_largest_ff;
      rd_en          = 1'b0;
      rd_addr        = idx_ff[IW-1:0];
      wr_en          = 1'b0;
      wr_addr        = idx_ff[IW-1:0];
      wr_data        = cur_ff;
      fin            = 1'b0;
      fin_status     = ffba_pkg::STAT_OK;
      fin_raddr      = '0;
      fin_largest    = '0;

      case (state_ff)
         ffba_pkg::S_IDLE: begin
            if (start) begin
               kind_in    = req_kind;
               baddr_in   = req_byte_address;
               owner_in   = req_owner_id;
               idx_in     = '0;
               any_in     = 1'b0;
               largest_in = '0;
               case (req_kind)
                  ffba_pkg::KIND_ADD: begin
                     if (add_bad) begin
                        fin        = 1'b1;
                        fin_status = ffba_pkg::STAT_SIZE;
                     end else if (cnt_ff >= MAXB) begin
                        fin        = 1'b1;
                        fin_status = ffba_pkg::STAT_FULL;
                     end else begin
                        need_in  = add_start[AB-1:0];
                        tail_in  = add_trim[AB-1:0] - HDR;
                        state_in = ffba_pkg::S_SCAN_RD;
                     end
                  end
                  ffba_pkg::KIND_ALLOC, ffba_pkg::KIND_SHRINK: begin
                     if (need_rnd[AB]) begin
                        fin        = 1'b1;
                        fin_status = ffba_pkg::STAT_SIZE;
                     end else begin
                        need_in  = need_rnd[AB-1:0];
                        state_in = ffba_pkg::S_SCAN_RD;
                     end
                  end
                  ffba_pkg::KIND_FREE_ADDR, ffba_pkg::KIND_FREE_OWNER,
                  ffba_pkg::KIND_LARGEST: begin
                     state_in = ffba_pkg::S_SCAN_RD;
                  end
                  default: begin
                     fin = 1'b1;
                  end
               endcase
            end
         end

         ffba_pkg::S_SCAN_RD: begin
            if (idx_ff < cnt_ff) begin
               rd_en    = 1'b1;
               state_in = ffba_pkg::S_SCAN_EV;
            end else begin
               case (kind_ff)
                  ffba_pkg::KIND_ADD: begin
                     pos_in   = cnt_ff;
                     kk_in    = cnt_ff;
                     ret_in   = ffba_pkg::S_ADD_WR;
                     state_in = ffba_pkg::S_SHU_RD;
                  end
                  ffba_pkg::KIND_ALLOC: begin
                     fin        = 1'b1;
                     fin_status = ffba_pkg::STAT_NO_FIT;
                  end
                  ffba_pkg::KIND_FREE_ADDR, ffba_pkg::KIND_SHRINK: begin
                     fin        = 1'b1;
                     fin_status = ffba_pkg::STAT_NOT_FOUND;
                  end
                  ffba_pkg::KIND_FREE_OWNER: begin
                     fin        = 1'b1;
                     fin_status = any_ff ? ffba_pkg::STAT_OK : ffba_pkg::STAT_NOT_FOUND;
                  end
                  ffba_pkg::KIND_LARGEST: begin
                     fin         = 1'b1;
                     fin_largest = largest_ff;
                  end
                  default: begin
                     fin = 1'b1;
                  end
               endcase
            end
         end

         ffba_pkg::S_SCAN_EV: begin
            state_in = ffba_pkg::S_SCAN_RD;
            case (kind_ff)
               ffba_pkg::KIND_ADD: begin
                  if (need_ff >= rd_q_ff.addr) begin
                     idx_in = idx_p1;
                  end else begin
                     pos_in   = idx_ff;
                     kk_in    = cnt_ff;
                     ret_in   = ffba_pkg::S_ADD_WR;
                     state_in = ffba_pkg::S_SHU_RD;
                  end
               end
               ffba_pkg::KIND_ALLOC: begin
                  if (!rd_q_ff.granted && (rd_q_ff.size >= need_ff)) begin
                     cur_in   = rd_q_ff;
                     at_in    = rd_q_ff.addr + HDR + need_ff;
                     tail_in  = alloc_rest - HDR;
                     split_in = (alloc_rest > HDR) && (cnt_ff < MAXB);
                     if ((alloc_rest > HDR) && (cnt_ff < MAXB)) begin
                        pos_in   = idx_p1;
                        kk_in    = cnt_ff;
                        ret_in   = ffba_pkg::S_ALLOC_NEW;
                        state_in = ffba_pkg::S_SHU_RD;
                     end else begin
                        state_in = ffba_pkg::S_ALLOC_CUR;
                     end
                  end else begin
                     idx_in = idx_p1;
                  end
               end
               ffba_pkg::KIND_FREE_ADDR, ffba_pkg::KIND_SHRINK: begin
                  if (({1'b0, rd_q_ff.addr} + HDR1) == {1'b0, baddr_ff}) begin
                     cur_in   = rd_q_ff;
                     state_in = (kind_ff == ffba_pkg::KIND_SHRINK) ? ffba_pkg::S_SHR_CHK
                                                                  : ffba_pkg::S_REL0;
                  end else begin
                     idx_in = idx_p1;
                  end
               end
               ffba_pkg::KIND_FREE_OWNER: begin
                  if (rd_q_ff.granted && (rd_q_ff.owner == owner_ff)) begin
                     any_in   = 1'b1;
                     cur_in   = rd_q_ff;
                     state_in = ffba_pkg::S_REL0;
                  end else begin
                     idx_in = idx_p1;
                  end
               end
               ffba_pkg::KIND_LARGEST: begin
                  if (!rd_q_ff.granted && (rd_q_ff.size > largest_ff)) begin
                     largest_in = rd_q_ff.size;
                  end
                  idx_in = idx_p1;
               end
               default: begin
                  fin = 1'b1;
               end
            endcase
         end

         // open a slot at pos: move entries up, last first
         ffba_pkg::S_SHU_RD: begin
            if (kk_ff > pos_ff) begin
               rd_en    = 1'b1;
               rd_addr  = kk_m1[IW-1:0];
               state_in = ffba_pkg::S_SHU_WR;
            end else begin
               cnt_in   = cnt_ff + CW'(1);
               state_in = ret_ff;
            end
         end
         ffba_pkg::S_SHU_WR: begin
            wr_en    = 1'b1;
            wr_addr  = kk_ff[IW-1:0];
            wr_data  = rd_q_ff;
            kk_in    = kk_m1;
            state_in = ffba_pkg::S_SHU_RD;
         end

         // close the slot at kk: move entries down
         ffba_pkg::S_SHD_RD: begin
            if (kk_p1 < cnt_ff) begin
               rd_en    = 1'b1;
               rd_addr  = kk_p1[IW-1:0];
               state_in = ffba_pkg::S_SHD_WR;
            end else begin
               cnt_in   = cnt_ff - CW'(1);
               state_in = ret_ff;
            end
         end
         ffba_pkg::S_SHD_WR: begin
            wr_en    = 1'b1;
            wr_addr  = kk_ff[IW-1:0];
            wr_data  = rd_q_ff;
            kk_in    = kk_p1;
            state_in = ffba_pkg::S_SHD_RD;
         end

         ffba_pkg::S_ADD_WR: begin
            wr_en           = 1'b1;
            wr_addr         = pos_ff[IW-1:0];
            wr_data.addr    = need_ff;
            wr_data.size    = tail_ff;
            wr_data.owner   = '0;
            wr_data.granted = 1'b0;
            wr_data.pinned  = 1'b1;
            fin             = 1'b1;
         end

         ffba_pkg::S_ALLOC_NEW: begin
            wr_en           = 1'b1;
            wr_addr         = idx_p1[IW-1:0];
            wr_data.addr    = at_ff;
            wr_data.size    = tail_ff;
            wr_data.owner   = '0;
            wr_data.granted = 1'b0;
            wr_data.pinned  = 1'b0;
            state_in        = ffba_pkg::S_ALLOC_CUR;
         end
         ffba_pkg::S_ALLOC_CUR: begin
            wr_en           = 1'b1;
            wr_data.granted = 1'b1;
            wr_data.owner   = owner_ff;
            wr_data.size    = split_ff ? need_ff : cur_ff.size;
            fin             = 1'b1;
            fin_raddr       = cur_ff.addr + HDR;
         end

         // release entry idx held in cur
         ffba_pkg::S_REL0: begin
            cur_in.granted = 1'b0;
            if (idx_p1 < cnt_ff) begin
               rd_en    = 1'b1;
               rd_addr  = idx_p1[IW-1:0];
               state_in = ffba_pkg::S_REL1;
            end else begin
               state_in = ffba_pkg::S_REL2;
            end
         end
         ffba_pkg::S_REL1: begin
            state_in = ffba_pkg::S_REL2;
            if (!rd_q_ff.granted && !rd_q_ff.pinned) begin
               cur_in.size = cur_ff.size + rd_q_ff.size + HDR;
               kk_in       = idx_p1;
               ret_in      = ffba_pkg::S_REL2;
               state_in    = ffba_pkg::S_SHD_RD;
            end
         end
         ffba_pkg::S_REL2: begin
            wr_en = 1'b1;
            if (!cur_ff.pinned && (idx_ff != '0)) begin
               rd_en    = 1'b1;
               rd_addr  = idx_m1[IW-1:0];
               state_in = ffba_pkg::S_REL3;
            end else begin
               merged_in = 1'b0;
               state_in  = ffba_pkg::S_REL_END;
            end
         end
         ffba_pkg::S_REL3: begin
            merged_in = 1'b0;
            state_in  = ffba_pkg::S_REL_END;
            if (!rd_q_ff.granted) begin
               wr_en        = 1'b1;
               wr_addr      = idx_m1[IW-1:0];
               wr_data      = rd_q_ff;
               wr_data.size = rd_q_ff.size + cur_ff.size + HDR;
               merged_in    = 1'b1;
               kk_in        = idx_ff;
               ret_in       = ffba_pkg::S_REL_END;
               state_in     = ffba_pkg::S_SHD_RD;
            end
         end
         ffba_pkg::S_REL_END: begin
            if (kind_ff == ffba_pkg::KIND_FREE_OWNER) begin
               if (!merged_ff) begin
                  idx_in = idx_p1;
               end
               state_in = ffba_pkg::S_SCAN_RD;
            end else begin
               fin = 1'b1;
            end
         end

         ffba_pkg::S_SHR_CHK: begin
            if ({1'b0, cur_ff.size} < ({1'b0, need_ff} + HDR1)) begin
               fin        = 1'b1;
               fin_status = ffba_pkg::STAT_SIZE;
            end else begin
               tail_in = cur_ff.size - need_ff - HDR;
               at_in   = cur_ff.addr + HDR + need_ff;
               if (idx_p1 < cnt_ff) begin
                  rd_en    = 1'b1;
                  rd_addr  = idx_p1[IW-1:0];
                  state_in = ffba_pkg::S_SHR_EV;
               end else begin
                  state_in = ffba_pkg::S_SHR_NOM;
               end
            end
         end
         ffba_pkg::S_SHR_EV: begin
            if (!rd_q_ff.granted && !rd_q_ff.pinned) begin
               wr_en        = 1'b1;
               wr_addr      = idx_p1[IW-1:0];
               wr_data      = rd_q_ff;
               wr_data.addr = at_ff;
               wr_data.size = rd_q_ff.size + tail_ff + HDR;
               state_in     = ffba_pkg::S_SHR_CUR;
            end else begin
               state_in = ffba_pkg::S_SHR_NOM;
            end
         end
         ffba_pkg::S_SHR_NOM: begin
            if (cnt_ff >= MAXB) begin
               fin        = 1'b1;
               fin_status = ffba_pkg::STAT_FULL;
            end else begin
               pos_in   = idx_p1;
               kk_in    = cnt_ff;
               ret_in   = ffba_pkg::S_SHR_NEW;
               state_in = ffba_pkg::S_SHU_RD;
            end
         end
         ffba_pkg::S_SHR_NEW: begin
            wr_en           = 1'b1;
            wr_addr         = idx_p1[IW-1:0];
            wr_data.addr    = at_ff;
            wr_data.size    = tail_ff;
            wr_data.owner   = '0;
            wr_data.granted = 1'b0;
            wr_data.pinned  = 1'b0;
            state_in        = ffba_pkg::S_SHR_CUR;
         end
         ffba_pkg::S_SHR_CUR: begin
            wr_en        = 1'b1;
            wr_data.size = need_ff;
            fin          = 1'b1;
         end

         default: begin
            state_in = ffba_pkg::S_IDLE;
         end
      endcase

      if (fin) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = fin_status;
         rsp_raddr_in   = fin_raddr;
         rsp_largest_in = fin_largest;
         state_in       = ffba_pkg::S_IDLE;
      end
   end

   assign busy               = (state_ff != ffba_pkg::S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_result_address = rsp_raddr_ff;
   assign rsp_largest_free   = rsp_largest_ff;

`ifndef ASSERT_OFF
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= MAXB)
      else $error("block count above table depth");

   a_rw_collide: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> (rd_addr != wr_addr))
      else $error("read and write of same entry in one cycle");

   a_beat_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy)
      else $error("response beat while still busy");

   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !busy || !rsp_valid_ff)
      else $error("response beat and busy together after accept");
`endif

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [ffba_pkg::ADDR_BITS-1:0] addr_type;
   typedef logic [ffba_pkg::OWNER_W-1:0]   owner_type;

   typedef struct {
      logic [ffba_pkg::KIND_W-1:0] kind;
      addr_type                    byte_address;
      addr_type                    byte_count;
      owner_type                   owner_id;
   } cmd_type;

   typedef struct {
      logic [ffba_pkg::STATUS_W-1:0] status;
      addr_type                      result_address;
      addr_type                      largest_free;
   } reply_type;

   typedef struct {
      longint unsigned addr;
      longint unsigned size;
      int unsigned     owner;
      bit              granted;
      bit              pinned;
   } blk_type;

   localparam longint unsigned AMASK = (64'd1 << ffba_pkg::ADDR_BITS) - 64'd1;
   localparam logic [ffba_pkg::KIND_W-1:0] KIND_UNDEF_LO = 3'd6;
   localparam logic [ffba_pkg::KIND_W-1:0] KIND_UNDEF_HI = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [ffba_pkg::KIND_W-1:0]   req_kind = '0;
   addr_type                      req_byte_address = '0;
   addr_type                      req_byte_count = '0;
   owner_type                     req_owner_id = '0;
   logic                          rsp_valid;
   logic [ffba_pkg::STATUS_W-1:0] rsp_status;
   addr_type                      rsp_result_address;
   addr_type                      rsp_largest_free;

   cmd_type   cmd_queue[$];
   reply_type expected_replies[$];
   blk_type   heap[$];
   int        errors = 0;
   bit        stim_done = 0;
   int        burst_left = 0;
   int        gap_left = 0;

   first_fit_block_allocator dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report(input string what, input longint unsigned got,
                         input longint unsigned want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic longint unsigned align_up(longint unsigned v);
      return ((v % ffba_pkg::ALIGN_BYTES) != 0)
             ? v + (ffba_pkg::ALIGN_BYTES - v % ffba_pkg::ALIGN_BYTES) : v;
   endfunction

   function automatic void merge_next(int i);
      heap[i].size = (heap[i].size + heap[i+1].size + ffba_pkg::HEADER_BYTES) & AMASK;
      heap.delete(i+1);
   endfunction

   function automatic bit free_block(int i);
      heap[i].granted = 0;
      if (i + 1 < heap.size() && !heap[i+1].granted && !heap[i+1].pinned) merge_next(i);
      if (!heap[i].pinned && i > 0 && !heap[i-1].granted) begin
         merge_next(i-1);
         return 1;
      end
      return 0;
   endfunction

   function automatic int find_payload(longint unsigned pa);
      foreach (heap[i]) if (heap[i].addr + ffba_pkg::HEADER_BYTES == pa) return i;
      return -1;
   endfunction

   function automatic blk_type free_blk(longint unsigned a, longint unsigned s, bit pin);
      blk_type b;
      b.addr    = a;
      b.size    = s;
      b.owner   = 0;
      b.granted = 1'b0;
      b.pinned  = pin;
      return b;
   endfunction

   function automatic reply_type allocator_step(cmd_type c);
      reply_type r;
      longint unsigned st, sz, need, tail, at;
      int i;
      bit bad, any;
      r.status = ffba_pkg::STAT_OK;
      r.result_address = '0;
      r.largest_free = '0;
      case (c.kind)
         ffba_pkg::KIND_ADD: begin
            st = 64'(c.byte_address);
            sz = 64'(c.byte_count);
            bad = 0;
            if ((st % ffba_pkg::ALIGN_BYTES) != 0) begin
               if (sz < ffba_pkg::ALIGN_BYTES - st % ffba_pkg::ALIGN_BYTES) bad = 1;
               else begin
                  sz -= ffba_pkg::ALIGN_BYTES - st % ffba_pkg::ALIGN_BYTES;
                  st += ffba_pkg::ALIGN_BYTES - st % ffba_pkg::ALIGN_BYTES;
               end
            end
            if (!bad) begin
               sz -= sz % ffba_pkg::ALIGN_BYTES;
               if (sz < ffba_pkg::HEADER_BYTES || st + sz > AMASK + 1) bad = 1;
            end
            if (bad) r.status = ffba_pkg::STAT_SIZE;
            else if (heap.size() >= ffba_pkg::MAX_BLOCKS) r.status = ffba_pkg::STAT_FULL;
            else begin
               i = 0;
               while (i < heap.size() && st >= heap[i].addr) i++;
               heap.insert(i, free_blk(st, sz - ffba_pkg::HEADER_BYTES, 1'b1));
            end
         end
         ffba_pkg::KIND_ALLOC: begin
            need = align_up(64'(c.byte_count));
            if (need > AMASK) r.status = ffba_pkg::STAT_SIZE;
            else begin
               r.status = ffba_pkg::STAT_NO_FIT;
               for (i = 0; i < heap.size(); i++) begin
                  if (!heap[i].granted && heap[i].size >= need) begin
                     if (heap[i].size - need > ffba_pkg::HEADER_BYTES
                         && heap.size() < ffba_pkg::MAX_BLOCKS) begin
                        heap.insert(i+1, free_blk(
                           (heap[i].addr + ffba_pkg::HEADER_BYTES + need) & AMASK,
                           heap[i].size - need - ffba_pkg::HEADER_BYTES, 1'b0));
                        heap[i].size = need;
                     end
                     heap[i].granted = 1;
                     heap[i].owner = 32'(c.owner_id);
                     r.result_address =
                        addr_type'((heap[i].addr + ffba_pkg::HEADER_BYTES) & AMASK);
                     r.status = ffba_pkg::STAT_OK;
                     break;
                  end
               end
            end
         end
         ffba_pkg::KIND_FREE_ADDR: begin
            i = find_payload(64'(c.byte_address));
            if (i < 0) r.status = ffba_pkg::STAT_NOT_FOUND;
            else void'(free_block(i));
         end
         ffba_pkg::KIND_FREE_OWNER: begin
            any = 0;
            i = 0;
            while (i < heap.size()) begin
               if (heap[i].granted && heap[i].owner == c.owner_id) begin
                  any = 1;
                  if (free_block(i)) continue;
               end
               i++;
            end
            if (!any) r.status = ffba_pkg::STAT_NOT_FOUND;
         end
         ffba_pkg::KIND_LARGEST: begin
            foreach (heap[k])
               if (!heap[k].granted && heap[k].size > r.largest_free)
                  r.largest_free = addr_type'(heap[k].size);
         end
         ffba_pkg::KIND_SHRINK: begin
            need = align_up(64'(c.byte_count));
            i = find_payload(64'(c.byte_address));
            if (need > AMASK) r.status = ffba_pkg::STAT_SIZE;
            else if (i < 0) r.status = ffba_pkg::STAT_NOT_FOUND;
            else if (heap[i].size < need + ffba_pkg::HEADER_BYTES)
               r.status = ffba_pkg::STAT_SIZE;
            else begin
               tail = heap[i].size - need - ffba_pkg::HEADER_BYTES;
               at = (heap[i].addr + ffba_pkg::HEADER_BYTES + need) & AMASK;
               if (i + 1 < heap.size() && !heap[i+1].granted && !heap[i+1].pinned) begin
                  heap[i+1].addr = at;
                  heap[i+1].size = (heap[i+1].size + tail + ffba_pkg::HEADER_BYTES) & AMASK;
                  heap[i].size = need;
               end else if (heap.size() >= ffba_pkg::MAX_BLOCKS)
                  r.status = ffba_pkg::STAT_FULL;
               else begin
                  heap.insert(i+1, free_blk(at, tail, 1'b0));
                  heap[i].size = need;
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic bit stim_done_pending();
      return cmd_queue.size() == 0;
   endfunction

   // driver: bursts with random gaps
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && !busy) && start) begin
         // hold current beat
      end else begin
         if (start) begin
            expected_replies.push_back(allocator_step(cmd_queue.pop_front()));
         end
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (cmd_queue.size() > 0) begin
            start <= 1'b1;
            req_kind <= cmd_queue[0].kind;
            req_byte_address <= cmd_queue[0].byte_address;
            req_byte_count <= cmd_queue[0].byte_count;
            req_owner_id <= cmd_queue[0].owner_id;
            if (burst_left > 0) burst_left--;
            else begin
               burst_left = $urandom_range(0, 20);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end
         end else begin
            start <= 1'b0;
            if (stim_done_pending()) stim_done = 1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      reply_type w;
      if (!reset && rsp_valid) begin
         if (expected_replies.size() == 0) begin
            report("unexpected beat", 64'(rsp_status), 64'd0);
         end else begin
            w = expected_replies.pop_front();
            if (rsp_status !== w.status)
               report("status", 64'(rsp_status), 64'(w.status));
            if (rsp_result_address !== w.result_address)
               report("result_address", 64'(rsp_result_address), 64'(w.result_address));
            if (rsp_largest_free !== w.largest_free)
               report("largest_free", 64'(rsp_largest_free), 64'(w.largest_free));
         end
      end
   end

   task automatic push(input logic [ffba_pkg::KIND_W-1:0] k, input addr_type a,
                       input addr_type n, input owner_type o);
      cmd_type c;
      c.kind = k;
      c.byte_address = a;
      c.byte_count = n;
      c.owner_id = o;
      cmd_queue.push_back(c);
   endtask

   initial begin
      int n, roll, k;
      for (k = 0; k < 12; k++) @(posedge clock);
      reset <= 1'b0;
      // directed
      push(ffba_pkg::KIND_LARGEST, '0, '0, '0);
      push(ffba_pkg::KIND_ALLOC, '0, 20'd16, 16'd1);
      push(ffba_pkg::KIND_ADD, 20'h00003, 20'h00002, '0);
      push(ffba_pkg::KIND_ADD, 20'hFFFF8, 20'h00100, '0);
      push(ffba_pkg::KIND_ADD, 20'h00000, 20'h0000F, '0);
      push(ffba_pkg::KIND_ADD, 20'h00005, 20'h01000, '0);
      push(ffba_pkg::KIND_ADD, 20'hFFFE0, 20'h00020, '0);
      push(ffba_pkg::KIND_ALLOC, '0, 20'hFFFFF, 16'hFFFF);
      push(ffba_pkg::KIND_ALLOC, '0, 20'hFFFF1, '0);
      push(ffba_pkg::KIND_ALLOC, '0, '0, 16'hFFFF);
      push(ffba_pkg::KIND_ALLOC, '0, 20'h00021, 16'hFFFF);
      push(ffba_pkg::KIND_ALLOC, '0, 20'h00010, 16'd7);
      push(ffba_pkg::KIND_LARGEST, '0, '0, '0);
      push(ffba_pkg::KIND_SHRINK, 20'h00020, '0, '0);
      push(ffba_pkg::KIND_SHRINK, 20'hFFFFF, 20'hFFFFF, '0);
      push(ffba_pkg::KIND_SHRINK, 20'h12345, '0, '0);
      push(ffba_pkg::KIND_SHRINK, 20'h00020, 20'h00400, '0);
      push(ffba_pkg::KIND_FREE_ADDR, 20'h00020, '0, '0);
      push(ffba_pkg::KIND_FREE_ADDR, 20'h00011, '0, '0);
      push(ffba_pkg::KIND_FREE_OWNER, '0, '0, 16'hFFFF);
      push(ffba_pkg::KIND_FREE_OWNER, '0, '0, 16'hFFFF);
      push(KIND_UNDEF_LO, 20'hFFFFF, 20'hFFFFF, 16'hFFFF);
      push(KIND_UNDEF_HI, '0, '0, '0);
      push(ffba_pkg::KIND_LARGEST, '0, '0, '0);
      // random: mostly well-formed allocate/free traffic on a few regions
      for (n = 0; n < 1900; n++) begin
         roll = $urandom_range(0, 99);
         if (n % 600 == 0)
            push(ffba_pkg::KIND_FREE_OWNER, '0, '0, owner_type'($urandom_range(0, 7)));
         if (roll < 6)
            push(ffba_pkg::KIND_ADD,
                 addr_type'(($urandom_range(0, 255) << 12) | $urandom_range(0, 31)),
                 addr_type'($urandom_range(0, 1) ? $urandom_range(0, 'hFFFFF)
                                                 : $urandom_range(0, 4096)),
                 owner_type'($urandom));
         else if (roll < 45) begin
            push(ffba_pkg::KIND_ALLOC, addr_type'($urandom),
                 addr_type'($urandom_range(0, 9) ? $urandom_range(0, 300)
                                                 : $urandom_range(0, 'hFFFFF)),
                 owner_type'($urandom_range(0, 7)));
         end else if (roll < 62)
            push(ffba_pkg::KIND_FREE_ADDR,
                 addr_type'($urandom_range(0, 3) ? ($urandom_range(0, 'hFFF) << 4)
                                                 : $urandom_range(0, 'hFFFFF)),
                 addr_type'($urandom), owner_type'($urandom));
         else if (roll < 70)
            push(ffba_pkg::KIND_FREE_OWNER, addr_type'($urandom), addr_type'($urandom),
                 owner_type'($urandom_range(0, 4) ? $urandom_range(0, 7)
                                                  : $urandom_range(0, 'hFFFF)));
         else if (roll < 78)
            push(ffba_pkg::KIND_LARGEST, addr_type'($urandom), addr_type'($urandom),
                 owner_type'($urandom));
         else if (roll < 96)
            push(ffba_pkg::KIND_SHRINK,
                 addr_type'($urandom_range(0, 3) ? ($urandom_range(0, 'hFFF) << 4)
                                                 : $urandom_range(0, 'hFFFFF)),
                 addr_type'($urandom_range(0, 9) ? $urandom_range(0, 200)
                                                 : $urandom_range(0, 'hFFFFF)),
                 owner_type'($urandom));
         else
            push(($urandom_range(0, 1) != 0) ? KIND_UNDEF_LO : KIND_UNDEF_HI,
                 addr_type'($urandom), addr_type'($urandom), owner_type'($urandom));
      end
      wait (stim_done);
      wait (expected_replies.size() == 0);
      for (k = 0; k < 600; k++) @(posedge clock);
      if (errors == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #4000000;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
